FILE: sv/q2e_pkg.sv
package q2e_pkg;

	localparam int TABLE_LEN = 25;
	// CORDIC datapath width: Q28 operands grow with the vector gain
	localparam int DW = 36;
	localparam int ZW = 27;

	localparam logic signed [ZW-1:0] HALF_PI_Q24 = 27'sd26353589;

	typedef logic signed [DW-1:0] dat_t;
	typedef logic signed [ZW-1:0] ang_t;

	typedef struct packed {
		dat_t x;
		dat_t y;
		ang_t z;
	} vec_t;

	function automatic ang_t atan_entry(input int i);
		ang_t t;
		unique case (i)
			0: t = 27'sd13176795;
			1: t = 27'sd7778716;
			2: t = 27'sd4110060;
			3: t = 27'sd2086331;
			4: t = 27'sd1047214;
			5: t = 27'sd524117;
			6: t = 27'sd262123;
			7: t = 27'sd131069;
			default: t = (i < TABLE_LEN) ? ang_t'(27'sd1 <<< (24 - i)) : '0;
		endcase
		return t;
	endfunction

endpackage

FILE: sv/q2e_cordic_cell.sv
module q2e_cordic_cell
	import q2e_pkg::*;
#(
	parameter int SHIFT = 0
) (
	input  logic clk,
	input  logic en,
	input  vec_t vec_in,
	output vec_t vec_out
);

	localparam ang_t ATAN_I = atan_entry(SHIFT);

	dat_t dx, dy;
	vec_t nxt;

	always_comb begin
		dx  = vec_in.y >>> SHIFT;
		dy  = vec_in.x >>> SHIFT;
		nxt = vec_in;
		if (!vec_in.y[DW-1] && vec_in.y != '0) begin
			nxt.x = vec_in.x + dx;
			nxt.y = vec_in.y - dy;
			nxt.z = vec_in.z + ATAN_I;
		end else if (vec_in.y[DW-1]) begin
			nxt.x = vec_in.x - dx;
			nxt.y = vec_in.y + dy;
			nxt.z = vec_in.z - ATAN_I;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vec_out <= nxt;
		end
	end

endmodule

FILE: sv/q2e_cordic_chain.sv
module q2e_cordic_chain
	import q2e_pkg::*;
#(
	parameter int STAGES = 16
) (
	input  logic clk,
	input  logic en,
	input  dat_t num,
	input  dat_t den,
	output ang_t angle
);

	vec_t pre_c;
	vec_t pre_s1;
	vec_t chain [STAGES+1];

	// turn left half plane into the right one
	always_comb begin
		pre_c.z = '0;
		if (den[DW-1]) begin
			if (!num[DW-1]) begin
				pre_c.x = num;
				pre_c.y = -den;
				pre_c.z = HALF_PI_Q24;
			end else begin
				pre_c.x = -num;
				pre_c.y = den;
				pre_c.z = -HALF_PI_Q24;
			end
		end else begin
			pre_c.x = den;
			pre_c.y = num;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pre_s1 <= pre_c;
		end
	end

	assign chain[0] = pre_s1;

	for (genvar i = 0; i < STAGES; i++) begin : g_cell
		q2e_cordic_cell #(.SHIFT(i)) u_cell (
			.clk(clk),
			.en(en),
			.vec_in(chain[i]),
			.vec_out(chain[i+1])
		);
	end

	assign angle = chain[STAGES].z;

endmodule

FILE: sv/q2e_sqrt_cell.sv
module q2e_sqrt_cell
	import q2e_pkg::*;
#(
	parameter int BITPOS = 56
) (
	input  logic        clk,
	input  logic        en,
	input  logic [56:0] rem_in,
	input  logic [56:0] res_in,
	output logic [56:0] rem_out,
	output logic [56:0] res_out
);

	localparam logic [56:0] BIT = 57'd1 << BITPOS;

	logic [57:0] trial;

	always_comb trial = {1'b0, res_in} + {1'b0, BIT};

	// one digit of the restoring root per cycle while en is high
	always_ff @(posedge clk) begin
		if (en) begin
			if ({1'b0, rem_in} >= trial) begin
				rem_out <= rem_in - trial[56:0];
				res_out <= (res_in >> 1) + BIT;
			end else begin
				rem_out <= rem_in;
				res_out <= res_in >> 1;
			end
		end
	end

endmodule

FILE: sv/quaternion_to_euler_angles.sv
// Quaternion (x, y, z, w, Q1.14) to roll, pitch and yaw in Q3.13, Q1.13
// and Q2.13 radians. One transfer is taken every cycle unless stalled.
// CORDIC stages are capped at 25. Registers: products, sums and clamp,
// square, the 29-digit square root cell row, the half-plane turn, the
// pitch CORDIC cell row and rounding register. Roll and yaw are delayed
// to match. A full pipe stalls as a whole while the output is not taken.
module quaternion_to_euler_angles
	import q2e_pkg::*;
#(
	parameter int CORDIC_STAGES = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] quat_x,
	input  logic signed [15:0] quat_y,
	input  logic signed [15:0] quat_z,
	input  logic signed [15:0] quat_w,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [16:0] roll_angle,
	output logic signed [14:0] pitch_angle,
	output logic signed [15:0] yaw_angle,
	output logic               pitch_clamped
);

	localparam int NST = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;
	localparam int SQN = 29;
	localparam int LAT = 3 + SQN + NST + 2;

	logic adv;
	logic [LAT-1:0] vld_q;

	// whole pipe advances when the last slot is free or taken
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end
	assign out_valid = vld_q[LAT-1];

	logic signed [31:0] p_xx, p_yy, p_zz, p_yz, p_wx, p_xy, p_wz, p_xz, p_wy;
	logic signed [36:0] rn_s1, rd_s1, yn_s1, yd_s1, ar_s1;
	logic signed [36:0] ar_c;
	logic               cl_c;
	logic signed [36:0] ar_s2;
	logic               cl_s2;
	dat_t rn_s2, rd_s2, yn_s2, yd_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			p_xx <= quat_x * quat_x; p_yy <= quat_y * quat_y;
			p_zz <= quat_z * quat_z; p_yz <= quat_y * quat_z;
			p_wx <= quat_w * quat_x; p_xy <= quat_x * quat_y;
			p_wz <= quat_w * quat_z; p_xz <= quat_x * quat_z;
			p_wy <= quat_w * quat_y;
		end
	end

	always_comb begin
		rn_s1 = 37'(p_yz) + 37'(p_wx);
		rd_s1 = 37'sd134217728 - 37'(p_xx) - 37'(p_yy);
		yn_s1 = 37'(p_xy) + 37'(p_wz);
		yd_s1 = 37'sd134217728 - 37'(p_yy) - 37'(p_zz);
		ar_s1 = (37'(p_wy) - 37'(p_xz)) <<< 1;
	end

	// clamp the arcsine argument to the unit range
	always_comb begin
		ar_c = ar_s1;
		cl_c = 1'b0;
		if (ar_s1 > 37'sd268435456) begin
			ar_c = 37'sd268435456; cl_c = 1'b1;
		end else if (ar_s1 < -37'sd268435456) begin
			ar_c = -37'sd268435456; cl_c = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rn_s2 <= DW'(rn_s1); rd_s2 <= DW'(rd_s1);
			yn_s2 <= DW'(yn_s1); yd_s2 <= DW'(yd_s1);
			cl_s2 <= cl_c;
			ar_s2 <= ar_c;
		end
	end

	logic [56:0] sq_a, sq_rem [SQN+1], sq_res [SQN+1];
	logic signed [29:0] ar_n;
	logic signed [59:0] aa;
	assign ar_n = ar_s2[29:0];
	always_comb aa = ar_n * ar_n;
	always_ff @(posedge clk) begin
		if (adv) begin
			sq_a <= 57'(58'd1 << 56) - aa[56:0];
		end
	end
	assign sq_rem[0] = sq_a;
	assign sq_res[0] = '0;
	for (genvar k = 0; k < SQN; k++) begin : g_sq
		q2e_sqrt_cell #(.BITPOS(56 - 2*k)) u_sq (
			.clk(clk), .en(adv), .rem_in(sq_rem[k]), .res_in(sq_res[k]),
			.rem_out(sq_rem[k+1]), .res_out(sq_res[k+1])
		);
	end

	localparam int D1 = SQN + 1;
	dat_t arg_d [D1+1], rn_d [D1+1], rd_d [D1+1], yn_d [D1+1], yd_d [D1+1];
	logic cl_d [D1+NST+2];
	assign arg_d[0] = DW'(ar_s2); assign rn_d[0] = rn_s2; assign rd_d[0] = rd_s2;
	assign yn_d[0] = yn_s2; assign yd_d[0] = yd_s2; assign cl_d[0] = cl_s2;
	for (genvar k = 0; k < D1; k++) begin : g_dl
		always_ff @(posedge clk) begin
			if (adv) begin
				arg_d[k+1] <= arg_d[k]; rn_d[k+1] <= rn_d[k]; rd_d[k+1] <= rd_d[k];
				yn_d[k+1] <= yn_d[k]; yd_d[k+1] <= yd_d[k];
			end
		end
	end
	for (genvar k = 0; k < D1 + NST + 1; k++) begin : g_cl
		always_ff @(posedge clk) begin
			if (adv) begin
				cl_d[k+1] <= cl_d[k];
			end
		end
	end

	ang_t a_roll, a_pitch, a_yaw;
	q2e_cordic_chain #(.STAGES(NST)) u_roll (.clk(clk), .en(adv), .num(rn_d[D1]),
		.den(rd_d[D1]), .angle(a_roll));
	q2e_cordic_chain #(.STAGES(NST)) u_pitch (.clk(clk), .en(adv), .num(arg_d[D1]),
		.den(DW'(sq_res[SQN])), .angle(a_pitch));
	q2e_cordic_chain #(.STAGES(NST)) u_yaw (.clk(clk), .en(adv), .num(yn_d[D1]),
		.den(yd_d[D1]), .angle(a_yaw));

	logic signed [ZW:0] r_r, r_p, r_y;
	always_comb begin
		r_r = ((ZW+1)'(a_roll) + (ZW+1)'(HALF_PI_Q24) + 28'sd1024) >>> 11;
		r_p = ((ZW+1)'(a_pitch) + 28'sd1024) >>> 11;
		r_y = ((ZW+1)'(a_yaw) + 28'sd1024) >>> 11;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			roll_angle  <= (r_r < -28'sd12868) ? -17'sd12868 :
				(r_r > 28'sd38604) ? 17'sd38604 : 17'(r_r);
			pitch_angle <= (r_p < -28'sd12868) ? -15'sd12868 :
				(r_p > 28'sd12868) ? 15'sd12868 : 15'(r_p);
			yaw_angle   <= (r_y < -28'sd25736) ? -16'sd25736 :
				(r_y > 28'sd25736) ? 16'sd25736 : 16'(r_y);
			pitch_clamped <= cl_d[D1+NST+1];
		end
	end

endmodule

FILE: sv/q2e_checker.sv
module q2e_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic signed [14:0] pitch_angle,
	input logic signed [15:0] yaw_angle
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pitch_angle)) else $error("hold");
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready) else $error("ready");
	a_pr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pitch_angle <= 15'sd12868 && pitch_angle >= -15'sd12868)
		else $error("pitch range");
	a_yr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> yaw_angle <= 16'sd25736 && yaw_angle >= -16'sd25736)
		else $error("yaw range");

endmodule

bind quaternion_to_euler_angles q2e_checker u_chk (.*);
